>>> rtl/core/assert_macros.svh
// Shared concurrent assertion macros; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define C2U_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("c2u: assertion failed");

// Checked at every edge, reset included.
`define C2U_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("c2u: assertion failed");

`endif

>>> rtl/core/c2u_pkg.sv
`default_nettype none
package c2u_pkg;

	localparam logic [11:0] EPOCH_YEAR = 12'd1970;
	// leap years in 1..1969
	localparam logic [10:0] LEAPS_BEFORE_EPOCH = 11'd477;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0] SECS_PER_MINUTE = 6'd60;
	// 41/1024 approximates 1/25, exact for quotients of values below 1024
	localparam logic [5:0] RECIP_25 = 6'd41;
	localparam logic [4:0] CENT_QUADS = 5'd25;
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] LAST_HOUR = 5'd23;
	localparam logic [5:0] LAST_MINUTE = 6'd59;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [5:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [5:0]  cent_prev;
		logic [5:0]  cent_year;
		logic        range_ok;
	} s1_t;

	typedef struct packed {
		logic        ok;
		logic [19:0] year_days;
		logic [8:0]  day_of_year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} s2_t;

	typedef struct packed {
		logic        ok;
		logic [19:0] days;
		logic [16:0] tod;
	} s3_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd1: r = 5'd31;
			4'd2: r = 5'd28;
			4'd3: r = 5'd31;
			4'd4: r = 5'd30;
			4'd5: r = 5'd31;
			4'd6: r = 5'd30;
			4'd7: r = 5'd31;
			4'd8: r = 5'd31;
			4'd9: r = 5'd30;
			4'd10: r = 5'd31;
			4'd11: r = 5'd30;
			4'd12: r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [8:0] days_ahead(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1: r = 9'd0;
			4'd2: r = 9'd31;
			4'd3: r = 9'd59;
			4'd4: r = 9'd90;
			4'd5: r = 9'd120;
			4'd6: r = 9'd151;
			4'd7: r = 9'd181;
			4'd8: r = 9'd212;
			4'd9: r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			4'd12: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/c2u_in_if.sv
`default_nettype none
interface c2u_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] calendar_year;
	logic [3:0]  month_number;
	logic [5:0]  day_of_month;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_value;
	logic [5:0]  second_value;

	modport source (
		output valid, calendar_year, month_number, day_of_month,
			hour_of_day, minute_value, second_value,
		input ready
	);
	modport sink (
		input valid, calendar_year, month_number, day_of_month,
			hour_of_day, minute_value, second_value,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/core/c2u_out_if.sv
`default_nettype none
interface c2u_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] unix_seconds;
	logic        date_valid;

	modport source (output valid, unix_seconds, date_valid, input ready);
	modport sink (input valid, unix_seconds, date_valid, output ready);
endinterface
`default_nettype wire

>>> rtl/core/c2u_front.sv
`default_nettype none
module c2u_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld,
	input  wire logic [11:0] calendar_year,
	input  wire logic [3:0]  month_number,
	input  wire logic [5:0]  day_of_month,
	input  wire logic [4:0]  hour_of_day,
	input  wire logic [5:0]  minute_value,
	input  wire logic [5:0]  second_value,
	output logic             vld_s1,
	output c2u_pkg::s1_t     data_s1
);
	logic [11:0] yr_prev;
	logic [15:0] prod_prev;
	logic [15:0] prod_year;
	logic        range_ok;

	// floor(y/100) = floor(floor(y/4)/25)
	always_comb begin
		yr_prev = calendar_year - 12'd1;
		prod_prev = 16'(yr_prev[11:2]) * 16'(c2u_pkg::RECIP_25);
		prod_year = 16'(calendar_year[11:2]) * 16'(c2u_pkg::RECIP_25);
		range_ok = (calendar_year >= c2u_pkg::EPOCH_YEAR) &&
			(month_number >= c2u_pkg::MONTH_JAN) &&
			(month_number <= c2u_pkg::MONTH_DEC) &&
			(day_of_month != 6'd0) &&
			(hour_of_day <= c2u_pkg::LAST_HOUR) &&
			(minute_value <= c2u_pkg::LAST_MINUTE) &&
			(second_value <= c2u_pkg::LAST_MINUTE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.year <= calendar_year;
			data_s1.month <= month_number;
			data_s1.day <= day_of_month;
			data_s1.hour <= hour_of_day;
			data_s1.minute <= minute_value;
			data_s1.second <= second_value;
			data_s1.cent_prev <= prod_prev[15:10];
			data_s1.cent_year <= prod_year[15:10];
			data_s1.range_ok <= range_ok;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/c2u_days.sv
`default_nettype none
module c2u_days (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vld_s1,
	input  c2u_pkg::s1_t      data_s1,
	output logic              vld_s3,
	output c2u_pkg::s3_t      data_s3
);
	logic [11:0] yr_prev;
	logic [11:0] year_off;
	logic [10:0] leaps;
	logic [20:0] year_days;
	logic        div4;
	logic        div100;
	logic        leap;
	logic [5:0]  max_day;
	logic [8:0]  day_of_year;
	logic        vld_s2;
	c2u_pkg::s2_t data_s2;
	logic [16:0] tod;

	always_comb begin
		yr_prev = data_s1.year - 12'd1;
		year_off = data_s1.year - c2u_pkg::EPOCH_YEAR;
		leaps = 11'(yr_prev[11:2]) - 11'(data_s1.cent_prev) +
			11'(data_s1.cent_prev[5:2]) - c2u_pkg::LEAPS_BEFORE_EPOCH;
		year_days = 21'(year_off) * 21'(c2u_pkg::DAYS_PER_YEAR) + 21'(leaps[9:0]);
		div4 = (data_s1.year[1:0] == 2'd0);
		div100 = div4 && (11'(data_s1.year[11:2]) ==
			11'(data_s1.cent_year) * 11'(c2u_pkg::CENT_QUADS));
		leap = div4 && (!div100 || (data_s1.cent_year[1:0] == 2'd0));
		max_day = 6'(c2u_pkg::month_len(data_s1.month)) +
			6'((data_s1.month == c2u_pkg::MONTH_FEB) && leap);
		day_of_year = c2u_pkg::days_ahead(data_s1.month) +
			9'((data_s1.month > c2u_pkg::MONTH_FEB) && leap) +
			9'(data_s1.day) - 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2.ok <= data_s1.range_ok && (data_s1.day <= max_day);
			data_s2.year_days <= year_days[19:0];
			data_s2.day_of_year <= day_of_year;
			data_s2.hour <= data_s1.hour;
			data_s2.minute <= data_s1.minute;
			data_s2.second <= data_s1.second;
		end
	end

	always_comb begin
		tod = 17'(data_s2.hour) * 17'(c2u_pkg::SECS_PER_HOUR) +
			17'(data_s2.minute) * 17'(c2u_pkg::SECS_PER_MINUTE) +
			17'(data_s2.second);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3.ok <= data_s2.ok;
			data_s3.days <= data_s2.year_days + 20'(data_s2.day_of_year);
			data_s3.tod <= tod;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/c2u_scale.sv
`default_nettype none
module c2u_scale (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     vld_s3,
	input  c2u_pkg::s3_t  data_s3,
	output logic          vld_s4,
	output logic [31:0]   secs_s4,
	output logic          ok_s4
);
	logic [36:0] day_secs;
	logic [31:0] total;

	// wraps modulo 2^32 past early 2106
	always_comb begin
		day_secs = 37'(data_s3.days) * 37'(c2u_pkg::SECS_PER_DAY);
		total = day_secs[31:0] + 32'(data_s3.tod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s4 <= data_s3.ok ? total : 32'd0;
			ok_s4 <= data_s3.ok;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/calendar_to_unix_seconds.sv
// Calendar date and time to 32-bit epoch seconds.
// An accepted request is registered through stages s1, s2, s3 and s4 before the result is valid.
// Throughput: one request per cycle; a stalled result freezes the whole pipe.
// The multiplies by 365 and 86400 and the leap count set the stage split.
// Reset (asynchronous, active low) clears all stage valid bits; no data reset.
`default_nettype none
module calendar_to_unix_seconds (
	input  wire logic  clk,
	input  wire logic  arst_n,
	c2u_in_if.sink     calendar,
	c2u_out_if.source  epoch
);
	logic         en;
	logic         vld_s1;
	logic         vld_s3;
	logic         vld_s4;
	c2u_pkg::s1_t data_s1;
	c2u_pkg::s3_t data_s3;

	assign en = !vld_s4 || epoch.ready;
	assign calendar.ready = en;
	assign epoch.valid = vld_s4;

	c2u_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.vld           (calendar.valid),
		.calendar_year (calendar.calendar_year),
		.month_number  (calendar.month_number),
		.day_of_month  (calendar.day_of_month),
		.hour_of_day   (calendar.hour_of_day),
		.minute_value  (calendar.minute_value),
		.second_value  (calendar.second_value),
		.vld_s1        (vld_s1),
		.data_s1       (data_s1)
	);

	c2u_days u_days (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1),
		.vld_s3  (vld_s3),
		.data_s3 (data_s3)
	);

	c2u_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s3  (vld_s3),
		.data_s3 (data_s3),
		.vld_s4  (vld_s4),
		.secs_s4 (epoch.unix_seconds),
		.ok_s4   (epoch.date_valid)
	);
endmodule
`default_nettype wire

>>> rtl/core/c2u_checker.sv
`default_nettype none
`include "assert_macros.svh"
module c2u_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] unix_seconds,
	input wire logic        date_valid
);
	`C2U_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`C2U_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(unix_seconds) && $stable(date_valid))
	`C2U_ASSERT(a_bad_date_zero, out_valid && !date_valid |-> unix_seconds == 32'd0)
	`C2U_ASSERT(a_stall_blocks_input, out_valid && !out_ready |-> !in_ready)
	`C2U_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid)
endmodule

bind calendar_to_unix_seconds c2u_checker u_c2u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (calendar.ready),
	.out_valid    (epoch.valid),
	.out_ready    (epoch.ready),
	.unix_seconds (epoch.unix_seconds),
	.date_valid   (epoch.date_valid)
);
`default_nettype wire
